[sv/deq_pkg.sv]
// Package: sizes, operation and status codes, and the cell command for the deque.
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OP_W = 3;
  localparam int POS_W = 4;
  localparam int ST_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic en;          // a word is accepted this cycle
    logic push_front;  // every cell takes its front-side neighbor
    logic pop_front;   // every cell takes its rear-side neighbor
    logic wr_en;       // one cell loads the input value
    idx_t wr_pos;
    logic rd_en;       // one cell drives the read tap
    idx_t rd_pos;
  } cell_cmd_t;

endpackage

[sv/deq_if.sv]
// Valid/ready channel interfaces for deque requests and responses.
interface deq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] value;
  logic [3:0]  position;

  modport source (output valid, operation, value, position, input ready);
  modport sink (input valid, operation, value, position, output ready);
endinterface

interface deq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic [31:0] first_value;
  logic [31:0] last_value;
  logic [4:0]  count;
  logic        is_empty;

  modport source (output valid, status, read_data, first_value, last_value, count, is_empty,
                  input ready);
  modport sink (input valid, status, read_data, first_value, last_value, count, is_empty,
                output ready);
endinterface

[sv/double_ended_queue.sv]
// Top level: bounded deque built as a row of shifting cells with a registered response.
// The response word is registered and appears in the cycle after its request is taken.
// Throughput: 1 request per cycle; the whole cell row updates in the accepting cycle.
// A request is taken while a finished response waits, as long as that one is taken too.
// Reset (synchronous, active high) empties the deque and drops the response valid;
// the cell contents are not cleared and are never shown until written.
module double_ended_queue (
  input logic       clk,
  input logic       rst,
  deq_in_if.sink    req,
  deq_out_if.source rsp
);
  import deq_pkg::*;

  // Entry count is the only control state; the front is always cell 0.
  cnt_t count;
  cnt_t count_next;

  cell_cmd_t cmd;
  status_t   status;
  logic      accept;

  word_t word      [DEPTH];
  word_t word_next [DEPTH];
  word_t rd_tap    [DEPTH];
  word_t last_tap  [DEPTH];
  word_t prev_word [DEPTH];
  word_t next_word [DEPTH];

  idx_t  last_pos;
  word_t rd_word;
  word_t last_word;

  // Output stage frees up whenever it is empty or being drained.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  deq_ctrl u_ctrl (
    .accept     (accept),
    .operation  (req.operation),
    .position   (req.position),
    .count      (count),
    .cmd        (cmd),
    .status     (status),
    .count_next (count_next)
  );

  // Rear entry after the operation sits at count_next - 1.
  assign last_pos = IDX_W'(count_next - 1'b1);

  // Neighbor wiring: cell 0 takes the pushed value on a front push,
  // the last cell keeps its word on a front pop (it falls out of the live range).
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prev_word[gi] = req.value;
      end else begin : g_body
        assign prev_word[gi] = word[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign next_word[gi] = word[gi];
      end else begin : g_mid
        assign next_word[gi] = word[gi+1];
      end

      deq_cell u_cell (
        .clk       (clk),
        .idx       (IDX_W'(gi)),
        .cmd       (cmd),
        .value     (req.value),
        .prev_word (prev_word[gi]),
        .next_word (next_word[gi]),
        .last_pos  (last_pos),
        .word      (word[gi]),
        .word_next (word_next[gi]),
        .rd_tap    (rd_tap[gi]),
        .last_tap  (last_tap[gi])
      );
    end
  endgenerate

  // Each cell gates its own tap; at most one is live, so OR them together.
  always_comb begin
    rd_word   = '0;
    last_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word   = rd_word | rd_tap[i];
      last_word = last_word | last_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response payload: front and rear reflect the state after the operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status;
      rsp.read_data   <= rd_word;
      rsp.first_value <= (count_next == '0) ? '0 : word_next[0];
      rsp.last_value  <= (count_next == '0) ? '0 : last_word;
      rsp.count       <= count_next;
      rsp.is_empty    <= (count_next == '0);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.count == '0)))
    else $error("empty flag disagrees with count");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && (count == CNT_W'(DEPTH)) &&
     ((req.operation == OP_PUSH_REAR) || (req.operation == OP_PUSH_FRONT)))
    |=> (rsp.status == ST_FULL) && (count == CNT_W'(DEPTH)))
    else $error("push into full deque not refused");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.operation == OP_CLEAR)) |=> (count == '0) && rsp.is_empty)
    else $error("clear left entries");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> (count == $past(count)))
    else $error("count moved without a request");
`endif

endmodule

[sv/deq_cell.sv]
// One storage cell of the deque row; cell k holds the entry k places from the front.
module deq_cell (
  input  logic               clk,
  input  deq_pkg::idx_t      idx,
  input  deq_pkg::cell_cmd_t cmd,
  input  deq_pkg::word_t     value,
  input  deq_pkg::word_t     prev_word,
  input  deq_pkg::word_t     next_word,
  input  deq_pkg::idx_t      last_pos,
  output deq_pkg::word_t     word,
  output deq_pkg::word_t     word_next,
  output deq_pkg::word_t     rd_tap,
  output deq_pkg::word_t     last_tap
);
  import deq_pkg::*;

  always_comb begin
    word_next = word;
    if (cmd.push_front) begin
      word_next = prev_word;
    end else if (cmd.pop_front) begin
      word_next = next_word;
    end else if (cmd.wr_en && (cmd.wr_pos == idx)) begin
      word_next = value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      word <= word_next;
    end
  end

  assign rd_tap   = (cmd.rd_en && (cmd.rd_pos == idx)) ? word : '0;
  assign last_tap = (last_pos == idx) ? word_next : '0;

endmodule

[sv/deq_ctrl.sv]
// Operation decode: status, new entry count and the command for the cell row.
module deq_ctrl (
  input  logic               accept,
  input  logic [2:0]         operation,
  input  logic [3:0]         position,
  input  deq_pkg::cnt_t      count,
  output deq_pkg::cell_cmd_t cmd,
  output deq_pkg::status_t   status,
  output deq_pkg::cnt_t      count_next
);
  import deq_pkg::*;

  logic full;
  logic empty;
  logic in_range;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign in_range = (CNT_W'(position) < count);

  always_comb begin
    cmd            = '0;
    cmd.en         = accept;
    cmd.wr_pos     = IDX_W'(position);
    cmd.rd_pos     = IDX_W'(position);
    status         = ST_OK;
    count_next     = count;
    case (op_t'(operation))
      OP_PUSH_REAR: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_pos = IDX_W'(count);
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.push_front = 1'b1;
          count_next     = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.pop_front = 1'b1;
          count_next    = count - 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          cmd.wr_en = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

[tb/sv/tb_double_ended_queue.sv]
// Self-checking bench for the deque: directed, fill, back-pressure, drain and random streams.
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // Opcode 7 is outside op_t; the block must treat it as a no-op with status ok.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_WORDS = 400;
  localparam int DRAIN_LIMIT = 2000;
  localparam int HOLD_CYCLES = 40;
  localparam int PRINT_LIMIT = 40;

  // One response word as the block should present it.
  typedef struct {
    status_t status;
    word_t   read_data;
    word_t   first_value;
    word_t   last_value;
    cnt_t    count;
    logic    is_empty;
  } deq_reply_t;

  logic clk = 1'b0;
  logic rst;

  deq_in_if  req_ch ();
  deq_out_if rsp_ch ();

  double_ended_queue dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Shadow deque: ring buffer with a head slot and a fill count.
  word_t shadow_slots [DEPTH];
  int    shadow_head = 0;
  int    shadow_count = 0;

  // Responses owed by the block, oldest first.
  deq_reply_t replies_due [$];

  int mismatches = 0;
  int replies_seen = 0;
  int idle_pct = 32;   // chance in percent that a side idles in a given cycle
  int hold_left = 0;   // receiver hold-off, counted down by the ready process

  // Apply one accepted request word to the shadow deque and return the response it owes.
  function automatic deq_reply_t apply_request(logic [OP_W-1:0] op, word_t val,
                                                logic [POS_W-1:0] pos);
    deq_reply_t r;
    r.status = ST_OK;
    r.read_data = '0;
    case (op)
      OP_PUSH_REAR: begin
        if (shadow_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_slots[(shadow_head + shadow_count) % DEPTH] = val;
          shadow_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_slots[shadow_head] = val;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      OP_POP_REAR: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
        end
      end
      OP_READ: begin
        if (int'(pos) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_data = shadow_slots[(shadow_head + int'(pos)) % DEPTH];
        end
      end
      OP_WRITE: begin
        if (int'(pos) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          shadow_slots[(shadow_head + int'(pos)) % DEPTH] = val;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        shadow_head = 0;
      end
      default: begin
      end
    endcase
    // Front and rear only show live entries; an empty deque shows zeros.
    if (shadow_count == 0) begin
      r.first_value = '0;
      r.last_value = '0;
    end else begin
      r.first_value = shadow_slots[shadow_head];
      r.last_value = shadow_slots[(shadow_head + shadow_count - 1) % DEPTH];
    end
    r.count = cnt_t'(shadow_count);
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[%0t] mismatch on reply %0d, %s: got %h, want %h",
               $realtime, replies_seen, what, got, want);
    end
  endtask

  // Offer one request word; returns at the rising edge where it is taken.
  // Valid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_request(input logic [OP_W-1:0] op, input word_t val,
                              input logic [POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.value <= val;
    req_ch.position <= pos;
    do @(posedge clk); while (!req_ch.ready);
    replies_due.push_back(apply_request(op, val, pos));
  endtask

  // Drop valid; must precede any wait in the stimulus or the last word would repeat.
  task automatic stop_sending();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_replies();
    stop_sending();
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic word_t random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Pick a request from a biased mix: push-heavy grows the deque, pop-heavy shrinks it.
  // Positions mostly land on live entries so reads and writes do real work.
  task automatic send_random_request(input int push_pct, input int pop_pct);
    int roll;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(99);
    if (roll == 0) begin
      op = OP_CLEAR;
    end else if (roll <= push_pct) begin
      op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    end else if (roll <= push_pct + pop_pct) begin
      op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
    end else begin
      op = $urandom_range(1) ? OP_READ : OP_WRITE;
    end
    if (shadow_count > 0 && $urandom_range(3) != 0) begin
      pos = POS_W'($urandom_range(shadow_count - 1));
    end else begin
      pos = POS_W'($urandom_range(DEPTH - 1));
    end
    send_request(op, random_word(), pos);
  endtask

  // Empty-deque errors, push front on empty, indexed access edges, no-op code, clear.
  task automatic test_directed();
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_POP_REAR, '0, '0);
    send_request(OP_READ, '0, '0);
    send_request(OP_WRITE, 32'h1234_5678, '0);
    send_request(OP_UNUSED, '1, '1);
    send_request(OP_PUSH_FRONT, 32'hA5A5_0001, '0);
    send_request(OP_PUSH_REAR, 32'hFFFF_FFFF, '0);
    send_request(OP_PUSH_FRONT, 32'h0000_0000, '0);
    send_request(OP_READ, '0, 4'd0);
    send_request(OP_READ, '0, 4'd1);
    send_request(OP_READ, '0, 4'd2);
    send_request(OP_READ, '0, 4'd3);
    send_request(OP_WRITE, 32'h8000_0000, 4'd2);
    send_request(OP_READ, '0, 4'd2);
    send_request(OP_POP_REAR, '0, '0);
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_READ, '0, 4'd15);
    send_request(OP_WRITE, 32'h0000_0001, 4'd15);
    send_request(OP_UNUSED, 32'hDEAD_BEEF, 4'd0);
    send_request(OP_CLEAR, '0, '0);
    send_request(OP_POP_REAR, '0, '0);
    send_request(OP_PUSH_REAR, 32'h5A5A_5A5A, '0);
    send_request(OP_POP_FRONT, '0, '0);
  endtask

  // Fill from both ends past full, touch the last index, then drain past empty.
  task automatic test_fill_to_full();
    for (int n = 0; n < DEPTH; n++) begin
      send_request((n % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR, random_word(), '0);
    end
    send_request(OP_PUSH_REAR, random_word(), '0);
    send_request(OP_PUSH_FRONT, random_word(), '0);
    send_request(OP_READ, '0, POS_W'(DEPTH - 1));
    send_request(OP_WRITE, random_word(), POS_W'(DEPTH - 1));
    send_request(OP_READ, '0, POS_W'(DEPTH - 1));
    send_request(OP_READ, '0, '0);
    for (int n = 0; n < DEPTH; n++) begin
      send_request((n % 2) ? OP_POP_FRONT : OP_POP_REAR, '0, '0);
    end
    send_request(OP_POP_FRONT, '0, '0);
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering words,
  // so the response register fills and the request side has to stall.
  task automatic test_back_pressure();
    int saved_idle;
    saved_idle = idle_pct;
    idle_pct = 0;
    stop_sending();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (int n = 0; n < 24; n++) begin
      if (n < DEPTH) begin
        send_request(OP_PUSH_REAR, random_word(), '0);
      end else begin
        send_request(OP_READ, '0, POS_W'(n % DEPTH));
      end
    end
    idle_pct = saved_idle;
  endtask

  // Sender goes quiet until every response is back, then resumes.
  task automatic test_pause_for_drain();
    for (int n = 0; n < 6; n++) send_random_request(30, 30);
    wait_for_replies();
    for (int n = 0; n < 6; n++) send_random_request(30, 30);
  endtask

  // Random traffic in phases of 40 words; starts with a stretch where neither side idles.
  task automatic test_random_traffic();
    int push_pct;
    int pop_pct;
    push_pct = 35;
    pop_pct = 35;
    idle_pct = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 80) idle_pct = 32;
      if (n % 125 == 124) wait_for_replies();
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: begin
            push_pct = 60;
            pop_pct = 15;
          end
          1: begin
            push_pct = 15;
            pop_pct = 60;
          end
          default: begin
            push_pct = 35;
            pop_pct = 35;
          end
        endcase
      end
      send_random_request(push_pct, pop_pct);
    end
  endtask

  // Response ready: held low during reset and any hold-off, else random idling.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Compare every taken response with the oldest one owed.
  always @(posedge clk) begin : reply_check
    deq_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("reply with none pending", 32'(rsp_ch.status), '0);
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.read_data !== want.read_data)
          report_mismatch("read_data", rsp_ch.read_data, want.read_data);
        if (rsp_ch.first_value !== want.first_value)
          report_mismatch("first_value", rsp_ch.first_value, want.first_value);
        if (rsp_ch.last_value !== want.last_value)
          report_mismatch("last_value", rsp_ch.last_value, want.last_value);
        if (rsp_ch.count !== want.count)
          report_mismatch("count", 32'(rsp_ch.count), 32'(want.count));
        if (rsp_ch.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(rsp_ch.is_empty), 32'(want.is_empty));
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.operation <= OP_PUSH_REAR;
    req_ch.value <= '0;
    req_ch.position <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_to_full();
    test_back_pressure();
    test_pause_for_drain();
    test_random_traffic();

    // Let the last responses come home, then a few edges to catch strays.
    stop_sending();
    for (int n = 0; n < DRAIN_LIMIT && replies_due.size() != 0; n++) @(posedge clk);
    if (replies_due.size() != 0) report_mismatch("replies never returned", '0,
                                                 32'(replies_due.size()));
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("** double_ended_queue: FAILED **");
    $finish;
  end

endmodule
